// ===== src/hhs_pkg.sv =====
// ----------------------------------------------------------------------------
// Heightfield height sampler package
// Shared field widths, request kinds and the side-band word that travels
// with a query through the divider pipeline.
// ----------------------------------------------------------------------------
package hhs_pkg;

  localparam int GRID_CELLS_DEF = 20;

  localparam int HEIGHT_W  = 16;
  localparam int POS_W     = 16;
  localparam int IDX_W     = 5;
  localparam int SPACING_W = 8;

  // Divider: magnitude of the rounded numerator over the cell spacing.
  localparam int DIV_W      = 28;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_W / DIV_STEPS;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef struct packed {
    logic                       zero;  // load or outside grid: height is 0
    logic                       oor;
    logic                       neg;   // numerator was negative
    logic signed [HEIGHT_W-1:0] h1;
  } hhs_side_t;

endpackage

// ===== src/hhs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hhs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== src/hhs_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides an unsigned magnitude by the cell spacing, four quotient bits per
// stage, and carries the query's side-band word alongside.
// ----------------------------------------------------------------------------
module hhs_div import hhs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [DIV_W-1:0]     dividend_i,
  input  logic [SPACING_W-1:0] divisor_i,
  input  hhs_side_t            side_i,
  output logic                 valid_o,
  output logic [DIV_W-1:0]     quot_o,
  output logic [SPACING_W-1:0] rem_o,
  output hhs_side_t            side_o
);

  logic                 vld_q [DIV_STAGES];
  logic [SPACING_W-1:0] rem_q [DIV_STAGES];
  logic [DIV_W-1:0]     dq_q  [DIV_STAGES];
  hhs_side_t            sd_q  [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic                 v_in;
    logic [SPACING_W-1:0] r_in;
    logic [DIV_W-1:0]     d_in;
    hhs_side_t            s_in;
    logic [SPACING_W-1:0] r_nx;
    logic [DIV_W-1:0]     d_nx;

    if (i == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = '0;
      assign d_in = dividend_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = vld_q[i-1];
      assign r_in = rem_q[i-1];
      assign d_in = dq_q[i-1];
      assign s_in = sd_q[i-1];
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_comb begin
      logic [SPACING_W:0]   t;
      logic [SPACING_W-1:0] r;
      logic [DIV_W-1:0]     d;
      r = r_in;
      d = d_in;
      t = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        t = {r, d[DIV_W-1]};
        d = {d[DIV_W-2:0], 1'b0};
        if (t >= {1'b0, divisor_i}) begin
          t    = t - {1'b0, divisor_i};
          d[0] = 1'b1;
        end
        r = t[SPACING_W-1:0];
      end
      r_nx = r;
      d_nx = d;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= r_nx;
        dq_q[i]  <= d_nx;
        sd_q[i]  <= s_in;
      end
    end
  end

  assign valid_o = vld_q[DIV_STAGES-1];
  assign quot_o  = dq_q[DIV_STAGES-1];
  assign rem_o   = rem_q[DIV_STAGES-1];
  assign side_o  = sd_q[DIV_STAGES-1];

endmodule

// ===== src/heightfield_height_sampler_unit.sv =====
// ----------------------------------------------------------------------------
// Heightfield height sampler
// Vertex height grid with load and triangle-interpolated height queries.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while the output side does not stall and
// returns one word per input word, in order. The seven-stage divider scales
// the plane numerator by the cell spacing. Vertex heights live in four RAM
// banks split by the parity of column and row, so the four corners of any
// cell are read at once. A load writes its bank in the cycle it is accepted.
// Every vertex a query touches must have been loaded since reset.
module heightfield_height_sampler_unit import hhs_pkg::*; #(
  parameter int GRID_CELLS = GRID_CELLS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: cell spacing.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [SPACING_W-1:0] cfg_data_i,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // grid_col[4:0], grid_row[9:5], height_value[25:10], query_x[41:26],
  // query_z[57:42], zero padding[63:58]
  input  logic [63:0]          s_axis_tdata,
  // req_type[0]
  input  logic [0:0]           s_axis_tuser,
  // Output stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // height[15:0]
  output logic [15:0]          m_axis_tdata,
  // out_of_range[0]
  output logic [0:0]           m_axis_tuser
);

  localparam int HALF       = GRID_CELLS / 2;
  localparam int CW         = $clog2(GRID_CELLS + 1);
  localparam int HALFV      = (GRID_CELLS + 2) / 2;
  localparam int BANK_DEPTH = HALFV * HALFV;
  localparam int AW         = $clog2(BANK_DEPTH);
  localparam int BW         = 14;
  localparam int KW         = CW + 2;
  localparam int OW         = POS_W + 8;
  localparam int DW         = HEIGHT_W + 1;
  localparam int PW         = 2 * DW;
  localparam int NW         = PW + 2;
  localparam int RW         = DIV_W + 2;

  // Configuration register.
  logic [SPACING_W-1:0] cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= SPACING_W'(1);
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Global pipeline advance.
  logic out_valid_q;
  logic adv;
  logic s_accept;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign s_accept      = s_axis_tvalid && adv;

  // Input fields.
  req_e                in_req;
  logic [IDX_W-1:0]    in_col;
  logic [IDX_W-1:0]    in_row;
  logic [HEIGHT_W-1:0] in_hv;
  logic [POS_W-1:0]    in_qx;
  logic [POS_W-1:0]    in_qz;

  assign in_req = req_e'(s_axis_tuser[0]);
  assign in_col = s_axis_tdata[4:0];
  assign in_row = s_axis_tdata[9:5];
  assign in_hv  = s_axis_tdata[25:10];
  assign in_qx  = s_axis_tdata[41:26];
  assign in_qz  = s_axis_tdata[57:42];

  // Stage 0: cell search. The whole-unit position is compared with every
  // cell boundary at once, and the count of boundaries passed is the index.
  logic signed [BW-1:0] s_b;
  logic signed [BW-1:0] tx;
  logic signed [BW-1:0] tz;
  logic [POS_W:0]       nqz;
  logic signed [BW-1:0] bnd_lo;
  logic signed [BW-1:0] bnd_hi;
  logic [GRID_CELLS-2:0] ge_x;
  logic [GRID_CELLS-2:0] ge_z;
  logic [CW-1:0]        cx0;
  logic [CW-1:0]        cz0;
  logic                 q_in_grid;
  logic                 load_oor;

  localparam logic signed [BW-1:0] LO_OFF = BW'(-HALF);
  localparam logic signed [BW-1:0] HI_OFF = BW'(GRID_CELLS - HALF);

  assign s_b    = $signed({{(BW-SPACING_W){1'b0}}, cfg_q});
  assign nqz    = -{in_qz[POS_W-1], in_qz};
  assign tx     = {{(BW-8){in_qx[POS_W-1]}}, in_qx[POS_W-1:8]};
  assign tz     = {{(BW-9){nqz[POS_W]}}, nqz[POS_W:8]};
  assign bnd_lo = LO_OFF * s_b;
  assign bnd_hi = HI_OFF * s_b;

  for (genvar k = 1; k < GRID_CELLS; k++) begin : g_bnd
    localparam logic signed [BW-1:0] KOFF = BW'(k - HALF);
    logic signed [BW-1:0] bnd;
    assign bnd       = KOFF * s_b;
    assign ge_x[k-1] = tx >= bnd;
    assign ge_z[k-1] = tz >= bnd;
  end

  assign cx0 = CW'($countones(ge_x));
  assign cz0 = CW'($countones(ge_z));
  // A zero spacing collapses all bounds to zero, so nothing is in the grid.
  assign q_in_grid = (tx >= bnd_lo) && (tx < bnd_hi) && (tz >= bnd_lo) && (tz < bnd_hi);
  assign load_oor  = (in_col > IDX_W'(GRID_CELLS)) || (in_row > IDX_W'(GRID_CELLS));

  // Load write port.
  logic [1:0]          wbank;
  logic [AW-1:0]       waddr;
  logic                wr_en;

  assign wbank = {in_col[0], in_row[0]};
  assign waddr = AW'(in_col[CW-1:1] * HALFV + in_row[CW-1:1]);
  assign wr_en = s_accept && (in_req == REQ_LOAD) && !load_oor;

  // Stage 1 registers.
  logic                    v1_q;
  logic                    q1_q;
  logic                    oor1_q;
  logic [CW-1:0]           cx1_q;
  logic [CW-1:0]           cz1_q;
  logic signed [POS_W-1:0] qx1_q;
  logic signed [POS_W-1:0] qz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= s_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q1_q   <= (in_req == REQ_QUERY);
      oor1_q <= (in_req == REQ_QUERY) ? !q_in_grid : load_oor;
      cx1_q  <= cx0;
      cz1_q  <= cz0;
      qx1_q  <= $signed(in_qx);
      qz1_q  <= $signed(in_qz);
    end
  end

  // Stage 1: corner reads and offsets from the far corner.
  logic signed [HEIGHT_W-1:0] bank_q [4];
  logic signed [KW-1:0]       kx;
  logic signed [KW-1:0]       kz;
  logic signed [OW-1:0]       s_o;
  logic signed [OW-1:0]       xoff;
  logic signed [OW-1:0]       zoff;
  logic signed [OW-1:0]       u_full;
  logic signed [OW-1:0]       w_full;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam int BC = b / 2;
    localparam int BR = b % 2;
    logic [CW-1:0] rcol;
    logic [CW-1:0] rrow;
    logic [AW-1:0] raddr;
    logic [HEIGHT_W-1:0] rdata;

    assign rcol  = (cx1_q[0] == 1'(BC)) ? cx1_q : CW'(cx1_q + 1'b1);
    assign rrow  = (cz1_q[0] == 1'(BR)) ? cz1_q : CW'(cz1_q + 1'b1);
    assign raddr = AW'(rcol[CW-1:1] * HALFV + rrow[CW-1:1]);

    hhs_ram #(
      .WIDTH (HEIGHT_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_en && (wbank == 2'(b))),
      .waddr_i (waddr),
      .wdata_i (in_hv),
      .re_i    (adv),
      .raddr_i (raddr),
      .rdata_o (rdata)
    );

    assign bank_q[b] = $signed(rdata);
  end

  assign kx     = $signed({2'b00, cx1_q}) + KW'(1) - KW'(HALF);
  assign kz     = $signed({2'b00, cz1_q}) - KW'(HALF);
  assign s_o    = $signed({{(OW-SPACING_W){1'b0}}, cfg_q});
  assign xoff   = (OW'(kx) * s_o) <<< 8;
  assign zoff   = (OW'(kz) * s_o) <<< 8;
  assign u_full = OW'(qx1_q) - xoff;
  assign w_full = OW'(qz1_q) + zoff;

  // Stage 2 registers.
  logic                 v2_q;
  logic                 zero2_q;
  logic                 oor2_q;
  logic                 pc2_q;
  logic                 pr2_q;
  logic signed [DW-1:0] u2_q;
  logic signed [DW-1:0] w2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero2_q <= !q1_q || oor1_q;
      oor2_q  <= oor1_q;
      pc2_q   <= cx1_q[0];
      pr2_q   <= cz1_q[0];
      u2_q    <= u_full[DW-1:0];
      w2_q    <= w_full[DW-1:0];
    end
  end

  // Stage 2: pick the triangle and set up the two products.
  logic signed [HEIGHT_W-1:0] ha;
  logic signed [HEIGHT_W-1:0] hb;
  logic signed [HEIGHT_W-1:0] hc;
  logic signed [HEIGHT_W-1:0] hd;
  logic signed [DW-1:0]       d0;
  logic signed [DW-1:0]       d3;
  logic signed [DW-1:0]       dac;
  logic signed [DW-1:0]       ddc;
  logic                       near_tri;

  assign ha       = bank_q[{pc2_q, pr2_q}];
  assign hb       = bank_q[{~pc2_q, pr2_q}];
  assign hc       = bank_q[{pc2_q, ~pr2_q}];
  assign hd       = bank_q[{~pc2_q, ~pr2_q}];
  assign d0       = DW'(ha) - DW'(hb);
  assign d3       = DW'(hd) - DW'(hb);
  assign dac      = DW'(ha) - DW'(hc);
  assign ddc      = DW'(hd) - DW'(hc);
  assign near_tri = w2_q > u2_q;

  logic                       v3_q;
  logic                       zero3_q;
  logic                       oor3_q;
  logic signed [HEIGHT_W-1:0] h13_q;
  logic signed [DW-1:0]       m1a_q;
  logic signed [DW-1:0]       m1b_q;
  logic signed [DW-1:0]       m2a_q;
  logic signed [DW-1:0]       m2b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero3_q <= zero2_q;
      oor3_q  <= oor2_q;
      h13_q   <= hb;
      m1a_q   <= near_tri ? -u2_q : u2_q;
      m1b_q   <= near_tri ? d0 : ddc;
      m2a_q   <= w2_q;
      m2b_q   <= near_tri ? dac : -d3;
    end
  end

  // Stage 3: the two products.
  logic                       v4_q;
  logic                       zero4_q;
  logic                       oor4_q;
  logic signed [HEIGHT_W-1:0] h14_q;
  logic signed [PW-1:0]       p1_q;
  logic signed [PW-1:0]       p2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      zero4_q <= zero3_q;
      oor4_q  <= oor3_q;
      h14_q   <= h13_q;
      p1_q    <= m1a_q * m1b_q;
      p2_q    <= m2a_q * m2b_q;
    end
  end

  // Stage 4: round half up, drop the fixed-point scale, split off the sign.
  logic signed [NW-1:0]    num;
  logic signed [DIV_W-1:0] num_sc;
  logic [DIV_W-1:0]        mag;
  hhs_side_t               side_in;

  assign num    = NW'(p1_q) + NW'(p2_q)
                + $signed({{(NW-SPACING_W-7){1'b0}}, cfg_q, 7'b0});
  assign num_sc = num[NW-1:8];
  assign mag    = num_sc[DIV_W-1] ? DIV_W'(-num_sc) : DIV_W'(num_sc);

  assign side_in.zero = zero4_q;
  assign side_in.oor  = oor4_q;
  assign side_in.neg  = num_sc[DIV_W-1];
  assign side_in.h1   = h14_q;

  logic                 div_valid;
  logic [DIV_W-1:0]     div_quot;
  logic [SPACING_W-1:0] div_rem;
  hhs_side_t            div_side;

  hhs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (v4_q),
    .dividend_i (mag),
    .divisor_i  (cfg_q),
    .side_i     (side_in),
    .valid_o    (div_valid),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .side_o     (div_side)
  );

  // Floor division of a negative numerator rounds the magnitude up.
  logic [RW-1:0]          q_up;
  logic signed [RW-1:0]   q_signed;
  logic signed [RW-1:0]   res;
  logic [HEIGHT_W-1:0]    res_sat;

  assign q_up     = RW'(div_quot) + RW'(div_rem != '0);
  assign q_signed = div_side.neg ? $signed(-q_up) : $signed(RW'(div_quot));
  assign res      = RW'(div_side.h1) + q_signed;

  always_comb begin
    priority if (res > RW'(32767)) begin
      res_sat = 16'h7FFF;
    end else if (res < -RW'(32768)) begin
      res_sat = 16'h8000;
    end else begin
      res_sat = res[HEIGHT_W-1:0];
    end
  end

  // Output register.
  logic [HEIGHT_W-1:0] out_h_q;
  logic                out_oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_h_q   <= div_side.zero ? '0 : res_sat;
      out_oor_q <= div_side.oor;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_h_q;
  assign m_axis_tuser[0] = out_oor_q;

`ifndef SYNTHESIS
  a_cell_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && q1_q && !oor1_q |-> (cx1_q < CW'(GRID_CELLS)) && (cz1_q < CW'(GRID_CELLS)))
    else $error("cell index outside grid marked in range");

  a_offsets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !zero2_q |-> (u2_q <= 0) && (w2_q <= 0))
    else $error("position offset from far corner is positive");

  a_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid && !div_side.zero |-> div_rem < cfg_q)
    else $error("divider remainder not below spacing");

  a_zero_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("out-of-range word carries a height");
`endif

endmodule

// ===== dv/tb_heightfield_height_sampler_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heightfield height sampler testbench
// Drives load and query words at random pace, predicts each result word from
// a local copy of the height grid and the cell spacing, and checks the output
// stream in order. Runs several spacing settings, including zero and 255.
// ----------------------------------------------------------------------------
module tb_heightfield_height_sampler_unit;
  import hhs_pkg::*;

  localparam int GRID    = GRID_CELLS_DEF;
  localparam int HALF    = GRID / 2;
  localparam int LIMIT   = 600000;
  localparam int DRAIN   = 30;
  localparam int N_RAND  = 1600;

  typedef struct {
    req_e        req;
    logic [4:0]  col;
    logic [4:0]  row;
    logic [15:0] hv;
    logic [15:0] qx;
    logic [15:0] qz;
    bit          typed;
    logic [15:0] exp_h;
    logic        exp_oor;
  } stim_row_t;

  typedef struct {
    logic [15:0] h;
    logic        oor;
  } height_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  heightfield_height_sampler_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  logic [15:0]  grid_h [0:GRID][0:GRID];
  logic [7:0]   spacing;
  height_word_t pending_heights[$];
  height_word_t typed_heights[$];
  bit           typed_flags[$];
  int           errors = 0;
  int           cycles = 0;
  bit           long_hold = 1'b0;
  bit           no_gaps = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("heightfield_height_sampler_unit verification failed");
      $finish;
    end
  end

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint vtx(longint c, longint r);
    return longint'($signed(grid_h[5'(c)][5'(r)]));
  endfunction

  // Works out the result word for one accepted word and updates the grid.
  function automatic height_word_t sample_height(req_e req, logic [4:0] col,
      logic [4:0] row, logic [15:0] hv, logic [15:0] qx, logic [15:0] qz);
    height_word_t r;
    longint s, dv, cx, cz, u, w, h1, d0, d2, d3, num, res;
    r.h = '0;
    r.oor = 1'b0;
    if (req == REQ_LOAD) begin
      if (col > GRID || row > GRID) r.oor = 1'b1;
      else grid_h[col][row] = hv;
      return r;
    end
    s = longint'(spacing);
    if (s == 0) begin
      r.oor = 1'b1;
      return r;
    end
    dv = 256 * s;
    cx = floor_div(longint'($signed(qx)), dv) + HALF;
    cz = floor_div(-longint'($signed(qz)), dv) + HALF;
    if (cx < 0 || cx >= GRID || cz < 0 || cz >= GRID) begin
      r.oor = 1'b1;
      return r;
    end
    u = longint'($signed(qx)) - (cx + 1 - HALF) * dv;
    w = longint'($signed(qz)) + (cz - HALF) * dv;
    h1 = vtx(cx + 1, cz);
    d0 = vtx(cx, cz) - h1;
    d2 = vtx(cx, cz + 1) - h1;
    d3 = vtx(cx + 1, cz + 1) - h1;
    // Upper-left triangle only when strictly above the diagonal.
    if (w > u) num = -u * d0 + w * (d0 - d2);
    else num = u * (d3 - d2) - w * d3;
    res = h1 + floor_div(num + 128 * s, dv);
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    r.h = res[15:0];
    return r;
  endfunction

  // Scoreboard: predict on input acceptance, compare on output acceptance.
  always @(posedge clk_i) begin
    height_word_t got, want;
    bit typed;
    if (s_axis_tvalid && s_axis_tready)
      pending_heights.push_back(sample_height(req_e'(s_axis_tuser[0]),
          s_axis_tdata[4:0], s_axis_tdata[9:5], s_axis_tdata[25:10],
          s_axis_tdata[41:26], s_axis_tdata[57:42]));
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_heights.size() == 0) begin
        $error("result word with no expectation: height %h oor %b",
               m_axis_tdata, m_axis_tuser[0]);
        errors++;
      end else begin
        want = pending_heights.pop_front();
        typed = typed_flags.pop_front();
        // Directed rows with a written-in answer override the prediction.
        if (typed) want = typed_heights.pop_front();
        got.h = m_axis_tdata;
        got.oor = m_axis_tuser[0];
        if (got.h !== want.h) begin
          $error("height: expected %h, actual %h", want.h, got.h);
          errors++;
        end
        if (got.oor !== want.oor) begin
          $error("out_of_range: expected %b, actual %b", want.oor, got.oor);
          errors++;
        end
      end
    end
  end

  // Receiver: random stalls per word, plus one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        m_axis_tready = 1'b0;
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end
      n = no_gaps ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        m_axis_tready = 1'b0;
        repeat (n) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  task automatic send_word(req_e req, logic [4:0] col, logic [4:0] row,
                           logic [15:0] hv, logic [15:0] qx, logic [15:0] qz,
                           bit typed, height_word_t ans);
    int n;
    n = no_gaps ? 0 : $urandom_range(0, 4);
    if (n > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (n) @(negedge clk_i);
    end
    typed_flags.push_back(typed);
    if (typed) typed_heights.push_back(ans);
    s_axis_tdata = {6'b0, qz, qx, hv, row, col};
    s_axis_tuser = req;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_heights.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);
  endtask

  task automatic write_spacing(logic [7:0] v);
    cfg_data_i = v;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    spacing = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_word();
    height_word_t none;
    longint s, dv, lo, hi, t;
    int pick;
    req_e req;
    logic [15:0] qx, qz;
    none = '{h: '0, oor: 1'b0};
    s = (spacing == 0) ? 1 : longint'(spacing);
    dv = 256 * s;
    pick = $urandom_range(0, 99);
    req = (pick < 35) ? REQ_LOAD : REQ_QUERY;
    qx = 16'($urandom);
    qz = 16'($urandom);
    if (pick >= 35 && pick < 80) begin
      lo = -HALF * dv; if (lo < -32768) lo = -32768;
      hi = HALF * dv - 1; if (hi > 32767) hi = 32767;
      qx = 16'(lo + longint'($urandom_range(0, 32'(hi - lo))));
      lo = -HALF * dv + 1; if (lo < -32768) lo = -32768;
      hi = HALF * dv; if (hi > 32767) hi = 32767;
      qz = 16'(lo + longint'($urandom_range(0, 32'(hi - lo))));
    end else if (pick >= 80 && pick < 90) begin
      // Point on a cell diagonal, where the triangle choice ties.
      t = -longint'($urandom_range(1, 32'(dv - 1)));
      qx = 16'((longint'($urandom_range(1, GRID)) - HALF) * dv + t);
      qz = 16'(-(longint'($urandom_range(0, GRID - 1)) - HALF) * dv + t);
    end
    send_word(req, 5'($urandom), 5'($urandom), 16'($urandom), qx, qz, 1'b0, none);
  endtask

  stim_row_t directed[] = '{
    '{REQ_LOAD,  5'd10, 5'd10, 16'h7fff, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{REQ_LOAD,  5'd11, 5'd10, 16'h8000, 16'hffff, 16'hffff, 1'b1, 16'h0000, 1'b0},
    '{REQ_LOAD,  5'd10, 5'd11, 16'h0100, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{REQ_LOAD,  5'd11, 5'd11, 16'hffff, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{REQ_LOAD,  5'd21, 5'd0,  16'h1234, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{REQ_LOAD,  5'd0,  5'd31, 16'h1234, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{REQ_LOAD,  5'd31, 5'd31, 16'hffff, 16'hffff, 16'hffff, 1'b1, 16'h0000, 1'b1},
    '{REQ_LOAD,  5'd0,  5'd0,  16'h5a5a, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{REQ_LOAD,  5'd20, 5'd20, 16'ha5a5, 16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},
    // Query exactly on vertex (10,10) returns its height.
    '{REQ_QUERY, 5'd0,  5'd0,  16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h7fff, 1'b0},
    '{REQ_QUERY, 5'd31, 5'd31, 16'hffff, 16'd156,  -16'sd100, 1'b0, 16'h0000, 1'b0},
    '{REQ_QUERY, 5'd0,  5'd0,  16'h0000, 16'd255,  -16'sd255, 1'b0, 16'h0000, 1'b0},
    '{REQ_QUERY, 5'd0,  5'd0,  16'h0000, 16'd128,  -16'sd10,  1'b0, 16'h0000, 1'b0},
    '{REQ_QUERY, 5'd0,  5'd0,  16'h0000, 16'd1,    -16'sd200, 1'b0, 16'h0000, 1'b0},
    '{REQ_QUERY, 5'd0,  5'd0,  16'h0000, 16'h8000, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{REQ_QUERY, 5'd0,  5'd0,  16'h0000, 16'h7fff, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{REQ_QUERY, 5'd0,  5'd0,  16'h0000, 16'h0000, 16'h8000, 1'b1, 16'h0000, 1'b1},
    '{REQ_QUERY, 5'd0,  5'd0,  16'h0000, 16'h0000, 16'h7fff, 1'b1, 16'h0000, 1'b1},
    '{REQ_QUERY, 5'd0,  5'd0,  16'h0000, -16'sd2561, 16'h0000, 1'b1, 16'h0000, 1'b1},
    '{REQ_QUERY, 5'd0,  5'd0,  16'h0000, 16'd2560, 16'h0000, 1'b1, 16'h0000, 1'b1}
  };

  initial begin
    logic [7:0] settings[5];
    height_word_t ans;
    settings = '{8'd1, 8'd255, 8'd0, 8'd7, 8'd3};
    spacing = 8'd1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    write_spacing(8'd1);
    foreach (directed[i]) begin
      ans = '{h: directed[i].exp_h, oor: directed[i].exp_oor};
      send_word(directed[i].req, directed[i].col, directed[i].row, directed[i].hv,
                directed[i].qx, directed[i].qz, directed[i].typed, ans);
    end

    // Fill the whole grid so that every later query reads loaded vertices.
    ans = '{h: '0, oor: 1'b0};
    for (int c = 0; c <= GRID; c++)
      for (int r = 0; r <= GRID; r++)
        send_word(REQ_LOAD, 5'(c), 5'(r), 16'($urandom), 16'($urandom),
                  16'($urandom), 1'b0, ans);

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_spacing(p < 5 ? settings[p] : 8'($urandom_range(1, 255)));
      no_gaps = (p == 3);
      for (int i = 0; i < (N_RAND - 441) / 6; i++) begin
        if (p == 1 && i == 20) long_hold = 1'b1;
        random_word();
      end
    end
    no_gaps = 1'b0;

    wait_idle();
    if (errors == 0) begin
      $display("heightfield_height_sampler_unit verification clean");
    end else begin
      $display("heightfield_height_sampler_unit verification failed");
    end
    $finish;
  end

endmodule
